/* hdl/bmp_pixel_row_decoder_macros.svh */
// Assertion macros shared by the decoder modules.
// Unless NO_ASSERTIONS is defined, each use expands to one labeled concurrent
// assertion clocked by clk_i and disabled while rst_ni is low; otherwise to nothing.
`ifndef BMP_PIXEL_ROW_DECODER_MACROS_SVH
`define BMP_PIXEL_ROW_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BPR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define BPR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define BPR_ASSERT_IMP(name, ante, cons)
`define BPR_ASSERT_NXT(name, ante, cons)
`endif
`endif

/* hdl/bpr_pkg.sv */
`timescale 1ns / 1ps

package bpr_pkg;

  localparam int DEF_MAX_WIDTH       = 4096;
  localparam int DEF_PALETTE_ENTRIES = 256;
  localparam int MAX_HEIGHT          = 4096;
  localparam int ROW_W               = $clog2(MAX_HEIGHT);
  localparam int DIM_W               = 13;
  localparam int BPP_W               = 5;
  localparam int CFG_IDX_W           = 2;
  localparam int RGB_W               = 24;
  localparam int K_W                 = 3;
  localparam int ROW_ALIGN_BITS      = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [BPP_W-1:0] BPP_MONO   = 5'd1;
  localparam logic [BPP_W-1:0] BPP_NIBBLE = 5'd4;
  localparam logic [BPP_W-1:0] BPP_BYTE   = 5'd8;
  localparam logic [BPP_W-1:0] BPP_TRUE   = 5'd24;

  localparam logic ACT_PALETTE = 1'b0;
  localparam logic ACT_DATA    = 1'b1;

  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;

  typedef struct packed {
    logic [BPP_W-1:0] bpp;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic             direct;
    logic [RGB_W-1:0] rgb;
    logic             row_end;
    logic             frame_end;
    logic             last_of_run;
  } pix_t;

  // Remainder of an 8-bit index by the table size, by restoring subtraction.
  function automatic logic [7:0] pal_wrap(input logic [7:0] idx, input int entries);
    logic [16:0] r;
    r = {9'd0, idx};
    for (int s = 7; s >= 0; s--) begin
      if (r >= 17'(entries << s)) begin
        r = r - 17'(entries << s);
      end
    end
    return r[7:0];
  endfunction

endpackage

/* hdl/bpr_if.sv */
`timescale 1ns / 1ps

interface bpr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] palette_index;
  logic [7:0] palette_red;
  logic [7:0] palette_green;
  logic [7:0] palette_blue;
  logic [7:0] data_byte;

  modport source (
    output valid, action, palette_index, palette_red, palette_green, palette_blue,
           data_byte,
    input  ready
  );
  modport sink (
    input  valid, action, palette_index, palette_red, palette_green, palette_blue,
           data_byte,
    output ready
  );
endinterface

interface bpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       row_end;
  logic       frame_end;
  logic       last_of_run;

  modport source (
    output valid, red, green, blue, row_end, frame_end, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, row_end, frame_end, last_of_run,
    output ready
  );
endinterface

/* hdl/bpr_palette_ram.sv */
`timescale 1ns / 1ps

module bpr_palette_ram #(
  parameter int ENTRIES = bpr_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(ENTRIES)-1:0]   waddr_i,
  input  logic [bpr_pkg::RGB_W-1:0]    wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(ENTRIES)-1:0]   raddr_i,
  output logic [bpr_pkg::RGB_W-1:0]    rdata_o
);

  logic [bpr_pkg::RGB_W-1:0] mem_q [ENTRIES];
  logic [bpr_pkg::RGB_W-1:0] rdata_q;

  // A read at the same edge as a write to that entry returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bpr_unpacker.sv */
`timescale 1ns / 1ps
`include "bmp_pixel_row_decoder_macros.svh"

module bpr_unpacker #(
  parameter int MAX_WIDTH       = bpr_pkg::DEF_MAX_WIDTH,
  parameter int PALETTE_ENTRIES = bpr_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bpr_pkg::cfg_t                        cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  bpr_pkg::in_item_t                    in_item_i,
  output logic                                 pal_we_o,
  output logic [$clog2(PALETTE_ENTRIES)-1:0]   pal_waddr_o,
  output logic [bpr_pkg::RGB_W-1:0]            pal_wdata_o,
  output logic                                 pal_re_o,
  output logic [$clog2(PALETTE_ENTRIES)-1:0]   pal_raddr_o,
  input  logic                                 pix_room_i,
  output logic                                 pix_fire_o,
  output bpr_pkg::pix_t                        pix_o
);

  import bpr_pkg::*;

  localparam int DIM_MAX    = (1 << DIM_W) - 1;
  localparam int WIDTH_CAP  = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
  localparam int WCL_W      = $clog2(WIDTH_CAP + 1);
  localparam int BITS_W     = $clog2(WIDTH_CAP * int'(BPP_TRUE) + ROW_ALIGN_BITS);
  localparam int STRIDE_MAX = ((WIDTH_CAP * int'(BPP_TRUE) + ROW_ALIGN_BITS - 1)
                               / ROW_ALIGN_BITS) * (ROW_ALIGN_BITS / 8);
  localparam int STR_W      = $clog2(STRIDE_MAX + 1);
  localparam int PAL_W      = $clog2(PALETTE_ENTRIES);

  logic [DIM_W-1:0]  w_full;
  logic [WCL_W-1:0]  w_cl;
  logic [DIM_W-1:0]  h_cl;
  logic [BITS_W-1:0] row_bits;
  logic              supported;
  logic [STR_W-1:0]  data_bytes;
  logic [STR_W-1:0]  stride;
  logic [STR_W:0]    byte_inc;
  logic              byte_live;
  logic              in_fire;
  logic              data_fire;

  logic              iss_valid_q;
  logic              iss_direct_q;
  logic [7:0]        iss_byte_q;
  logic [K_W-1:0]    iss_k_q;
  logic [RGB_W-1:0]  iss_rgb_q;
  logic [WCL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [STR_W-1:0]  byte_q;
  logic [1:0]        phase_q;
  logic [7:0]        held_blue_q;
  logic [7:0]        held_green_q;

  logic              col_last;
  logic              row_last;
  logic              per_last;
  logic              run_last;
  logic [7:0]        idx;
  logic [7:0]        idx_wrap;

  always_comb begin
    if (cfg_i.width == '0) begin
      w_full = DIM_W'(1);
    end else if (cfg_i.width > DIM_W'(WIDTH_CAP)) begin
      w_full = DIM_W'(WIDTH_CAP);
    end else begin
      w_full = cfg_i.width;
    end
    w_cl = w_full[WCL_W-1:0];
    if (cfg_i.height == '0) begin
      h_cl = DIM_W'(1);
    end else if (cfg_i.height > DIM_W'(MAX_HEIGHT)) begin
      h_cl = DIM_W'(MAX_HEIGHT);
    end else begin
      h_cl = cfg_i.height;
    end
  end

  always_comb begin
    supported = 1'b1;
    case (cfg_i.bpp)
      BPP_MONO:   row_bits = BITS_W'(w_cl);
      BPP_NIBBLE: row_bits = BITS_W'(w_cl) << 2;
      BPP_BYTE:   row_bits = BITS_W'(w_cl) << 3;
      BPP_TRUE:   row_bits = (BITS_W'(w_cl) << 4) + (BITS_W'(w_cl) << 3);
      default: begin
        row_bits  = '0;
        supported = 1'b0;
      end
    endcase
  end

  assign data_bytes = STR_W'((row_bits + BITS_W'(7)) >> 3);
  assign stride     = STR_W'(((row_bits + BITS_W'(ROW_ALIGN_BITS - 1)) >> 5) << 2);
  assign byte_inc   = {1'b0, byte_q} + (STR_W+1)'(1);
  assign byte_live  = byte_q < data_bytes;

  assign col_last = ({1'b0, col_q} + (WCL_W+1)'(1)) >= {1'b0, w_cl};
  assign row_last = (DIM_W'(row_q) + DIM_W'(1)) >= h_cl;

  always_comb begin
    case (cfg_i.bpp)
      BPP_MONO: begin
        idx      = {7'd0, iss_byte_q[3'd7 - iss_k_q]};
        per_last = iss_k_q == K_W'(7);
      end
      BPP_NIBBLE: begin
        idx      = iss_k_q[0] ? {4'd0, iss_byte_q[3:0]} : {4'd0, iss_byte_q[7:4]};
        per_last = iss_k_q == K_W'(1);
      end
      default: begin
        idx      = iss_byte_q;
        per_last = 1'b1;
      end
    endcase
  end

  assign idx_wrap   = pal_wrap(idx, PALETTE_ENTRIES);
  assign run_last   = iss_direct_q || per_last || col_last;
  assign pix_fire_o = iss_valid_q && pix_room_i;
  assign in_ready_o = !iss_valid_q || (pix_fire_o && run_last);
  assign in_fire    = in_valid_i && in_ready_o;
  assign data_fire  = in_fire && (in_item_i.action == ACT_DATA) && supported;

  assign pal_we_o    = in_fire && (in_item_i.action == ACT_PALETTE)
                       && ({1'b0, in_item_i.palette_index} < 9'(PALETTE_ENTRIES));
  assign pal_waddr_o = in_item_i.palette_index[PAL_W-1:0];
  assign pal_wdata_o = {in_item_i.palette_red, in_item_i.palette_green,
                        in_item_i.palette_blue};
  assign pal_re_o    = pix_fire_o && !iss_direct_q;
  assign pal_raddr_o = idx_wrap[PAL_W-1:0];

  always_comb begin
    pix_o.direct      = iss_direct_q;
    pix_o.rgb         = iss_rgb_q;
    pix_o.row_end     = col_last;
    pix_o.frame_end   = col_last && row_last;
    pix_o.last_of_run = run_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_valid_q  <= 1'b0;
      iss_direct_q <= 1'b0;
      iss_byte_q   <= '0;
      iss_k_q      <= '0;
      iss_rgb_q    <= '0;
      col_q        <= '0;
      row_q        <= '0;
      byte_q       <= '0;
      phase_q      <= PH_BLUE;
      held_blue_q  <= '0;
      held_green_q <= '0;
    end else begin
      if (pix_fire_o) begin
        iss_k_q <= iss_k_q + K_W'(1);
        if (col_last) begin
          col_q <= '0;
          if (row_last) begin
            row_q <= '0;
          end else begin
            row_q <= row_q + ROW_W'(1);
          end
        end else begin
          col_q <= col_q + WCL_W'(1);
        end
        if (run_last) begin
          iss_valid_q <= 1'b0;
        end
      end
      if (data_fire) begin
        if (byte_inc >= {1'b0, stride}) begin
          byte_q <= '0;
        end else begin
          byte_q <= byte_inc[STR_W-1:0];
        end
        if (byte_live) begin
          if (cfg_i.bpp == BPP_TRUE) begin
            case (phase_q)
              PH_BLUE: begin
                held_blue_q <= in_item_i.data_byte;
                phase_q     <= PH_GREEN;
              end
              PH_GREEN: begin
                held_green_q <= in_item_i.data_byte;
                phase_q      <= PH_RED;
              end
              default: begin
                iss_valid_q  <= 1'b1;
                iss_direct_q <= 1'b1;
                iss_rgb_q    <= {in_item_i.data_byte, held_green_q, held_blue_q};
                iss_k_q      <= '0;
                phase_q      <= PH_BLUE;
              end
            endcase
          end else begin
            iss_valid_q  <= 1'b1;
            iss_direct_q <= 1'b0;
            iss_byte_q   <= in_item_i.data_byte;
            iss_k_q      <= '0;
          end
        end
      end
    end
  end

  `BPR_ASSERT_IMP(a_idle_ready, !iss_valid_q, in_ready_o)
  `BPR_ASSERT_IMP(a_direct_first, iss_valid_q && iss_direct_q, iss_k_q == '0)
  `BPR_ASSERT_NXT(a_run_drains, pix_fire_o && run_last && !in_fire, !iss_valid_q)

endmodule

/* hdl/bmp_pixel_row_decoder.sv */
`timescale 1ns / 1ps
`include "bmp_pixel_row_decoder_macros.svh"

// Bitmap pixel-array decoder. Items arrive on in_i: a palette item writes one
// entry of the color table, a data item carries the next byte of the pixel
// array in file order. Decoded pixels leave on out_o with row, frame and
// end-of-byte flags. Registers are written on cfg_we_i; the user must write
// them only while the block is idle, which the block itself does not enforce.
// A byte's first pixel passes the unpack and output registers to out_o. In
// 8- and 24-bit modes a byte is taken every cycle while out_o does not stall.
// In 4-bit mode a byte yields two pixels and in 1-bit mode up to eight, one
// palette RAM read per pixel; the byte is held until its last pixel issues,
// and the last pixel of a row may end a byte early. Padding bytes and palette
// items produce no pixel. Reset clears the counters and the held color bytes
// and restores 24 bits per pixel with a one-by-one image; the palette RAM is
// not cleared and holds undefined data until written. When out_o stalls, the
// output stage holds its pixel; in_i.ready falls once the unpack stage is full.
module bmp_pixel_row_decoder #(
  parameter int MAX_WIDTH       = bpr_pkg::DEF_MAX_WIDTH,
  parameter int PALETTE_ENTRIES = bpr_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bpr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bpr_pkg::DIM_W-1:0]          cfg_data_i,
  bpr_in_if.sink                             in_i,
  bpr_out_if.source                          out_o
);

  import bpr_pkg::*;

  localparam int PAL_W = $clog2(PALETTE_ENTRIES);

  cfg_t             cfg_q;
  in_item_t         in_item;
  logic             in_ready;
  logic             pal_we;
  logic [PAL_W-1:0] pal_waddr;
  logic [RGB_W-1:0] pal_wdata;
  logic             pal_re;
  logic [PAL_W-1:0] pal_raddr;
  logic [RGB_W-1:0] pal_rdata;
  logic             pix_fire;
  pix_t             pix;
  logic             s1_room;
  logic             s1_valid_q;
  pix_t             s1_pix_q;
  logic [RGB_W-1:0] rgb_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bpp    <= BPP_TRUE;
      cfg_q.width  <= DIM_W'(1);
      cfg_q.height <= DIM_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BPP:    cfg_q.bpp    <= cfg_data_i[BPP_W-1:0];
        CFG_WIDTH:  cfg_q.width  <= cfg_data_i;
        CFG_HEIGHT: cfg_q.height <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_item.action        = in_i.action;
    in_item.palette_index = in_i.palette_index;
    in_item.palette_red   = in_i.palette_red;
    in_item.palette_green = in_i.palette_green;
    in_item.palette_blue  = in_i.palette_blue;
    in_item.data_byte     = in_i.data_byte;
  end

  assign in_i.ready = in_ready;

  bpr_unpacker #(
    .MAX_WIDTH       (MAX_WIDTH),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_unpacker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .pal_we_o    (pal_we),
    .pal_waddr_o (pal_waddr),
    .pal_wdata_o (pal_wdata),
    .pal_re_o    (pal_re),
    .pal_raddr_o (pal_raddr),
    .pix_room_i  (s1_room),
    .pix_fire_o  (pix_fire),
    .pix_o       (pix)
  );

  bpr_palette_ram #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (pal_wdata),
    .re_i    (pal_re),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  assign s1_room = !s1_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_pix_q   <= '0;
    end else if (s1_room) begin
      s1_valid_q <= pix_fire;
      if (pix_fire) begin
        s1_pix_q <= pix;
      end
    end
  end

  assign rgb_sel           = s1_pix_q.direct ? s1_pix_q.rgb : pal_rdata;
  assign out_o.valid       = s1_valid_q;
  assign out_o.red         = rgb_sel[23:16];
  assign out_o.green       = rgb_sel[15:8];
  assign out_o.blue        = rgb_sel[7:0];
  assign out_o.row_end     = s1_pix_q.row_end;
  assign out_o.frame_end   = s1_pix_q.frame_end;
  assign out_o.last_of_run = s1_pix_q.last_of_run;

  `BPR_ASSERT_NXT(a_rdata_hold, s1_valid_q && !out_o.ready, $stable(pal_rdata))
  `BPR_ASSERT_IMP(a_fire_room, pix_fire, s1_room)
  `BPR_ASSERT_IMP(a_frame_row, s1_valid_q && s1_pix_q.frame_end, s1_pix_q.row_end)

endmodule

/* tb/bpr_checker.sv */
`timescale 1ns / 1ps

module bpr_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bpr_pkg::DIM_W-1:0]     cfg_data_i,
  bpr_in_if                             in_mon,
  bpr_out_if                            out_mon,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            pixel_count_o
);
  import bpr_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
    logic       last_of_run;
  } pixel_t;

  logic [RGB_W-1:0] color_table [DEF_PALETTE_ENTRIES];
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      byte_pos;
  logic [1:0]       color_phase;
  logic [7:0]       held_blue;
  logic [7:0]       held_green;
  logic [BPP_W-1:0] depth;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  pixel_t           exp_pixels [$];
  int               fails = 0;
  int               pixels = 0;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  task automatic push_pixel(logic [RGB_W-1:0] rgb, logic last);
    pixel_t      p;
    int unsigned w;
    int unsigned h;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    p.red         = rgb[23:16];
    p.green       = rgb[15:8];
    p.blue        = rgb[7:0];
    p.row_end     = 1'b0;
    p.frame_end   = 1'b0;
    p.last_of_run = last;
    if (col_pos + 1 >= w) begin
      p.row_end = 1'b1;
      col_pos   = 0;
      if (row_pos + 1 >= h) begin
        p.frame_end = 1'b1;
        row_pos     = 0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    exp_pixels.push_back(p);
  endtask

  task automatic decode_byte(logic [7:0] b);
    int unsigned w;
    int unsigned bpp;
    int unsigned bits;
    int unsigned data_bytes;
    int unsigned stride;
    int unsigned per;
    int unsigned mask;
    int unsigned idx;
    logic        stop;
    if (depth != BPP_MONO && depth != BPP_NIBBLE && depth != BPP_BYTE && depth != BPP_TRUE) begin
      return;
    end
    bpp        = depth;
    w          = clamp_dim(width_reg, DEF_MAX_WIDTH);
    bits       = w * bpp;
    data_bytes = (bits + 7) / 8;
    stride     = ((bits + ROW_ALIGN_BITS - 1) / ROW_ALIGN_BITS) * 4;
    if (byte_pos < data_bytes) begin
      if (depth == BPP_TRUE) begin
        case (color_phase)
          PH_BLUE: begin
            held_blue   = b;
            color_phase = PH_GREEN;
          end
          PH_GREEN: begin
            held_green  = b;
            color_phase = PH_RED;
          end
          default: begin
            push_pixel({b, held_green, held_blue}, 1'b1);
            color_phase = PH_BLUE;
          end
        endcase
      end else begin
        per  = 8 / bpp;
        mask = (1 << bpp) - 1;
        for (int k = 0; k < per; k++) begin
          idx  = (b >> (8 - bpp - k * bpp)) & mask;
          stop = (col_pos + 1 >= w);
          push_pixel(color_table[idx % DEF_PALETTE_ENTRIES], (k + 1 == per) || stop);
          if (stop) break;
        end
      end
    end
    byte_pos = (byte_pos + 1 >= stride) ? 0 : byte_pos + 1;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      col_pos     = 0;
      row_pos     = 0;
      byte_pos    = 0;
      color_phase = PH_BLUE;
      held_blue   = '0;
      held_green  = '0;
      depth       = BPP_TRUE;
      width_reg   = 1;
      height_reg  = 1;
      exp_pixels.delete();
      fail_count_o  <= fails;
      pending_o     <= 0;
      pixel_count_o <= pixels;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BPP:    depth = cfg_data_i[BPP_W-1:0];
          CFG_WIDTH:  width_reg = cfg_data_i;
          CFG_HEIGHT: height_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == ACT_PALETTE) begin
          color_table[in_mon.palette_index] =
            {in_mon.palette_red, in_mon.palette_green, in_mon.palette_blue};
        end else begin
          decode_byte(in_mon.data_byte);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (exp_pixels.size() == 0) begin
          $error("unexpected pixel: red %0d green %0d blue %0d",
                 out_mon.red, out_mon.green, out_mon.blue);
          fails++;
        end else begin
          want = exp_pixels.pop_front();
          check_field("red", want.red, out_mon.red);
          check_field("green", want.green, out_mon.green);
          check_field("blue", want.blue, out_mon.blue);
          check_field("row_end", want.row_end, out_mon.row_end);
          check_field("frame_end", want.frame_end, out_mon.frame_end);
          check_field("last_of_run", want.last_of_run, out_mon.last_of_run);
          pixels++;
        end
      end
      fail_count_o  <= fails;
      pending_o     <= exp_pixels.size();
      pixel_count_o <= pixels;
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import bpr_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DIM_W-1:0]     cfg_data_i;

  int fail_count;
  int pending;
  int pixel_count;

  bit               pal_written [DEF_PALETTE_ENTRIES];
  logic [BPP_W-1:0] cur_bpp = BPP_TRUE;
  bit               calm = 1'b0;
  int               items_sent = 0;
  int               settings_used = 0;

  bpr_in_if  in_if ();
  bpr_out_if out_if ();

  bmp_pixel_row_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  bpr_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .pixel_count_o (pixel_count)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_item(in_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.action        <= it.action;
    in_if.palette_index <= it.palette_index;
    in_if.palette_red   <= it.palette_red;
    in_if.palette_green <= it.palette_green;
    in_if.palette_blue  <= it.palette_blue;
    in_if.data_byte     <= it.data_byte;
    in_if.valid         <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send_palette(logic [7:0] idx, logic [RGB_W-1:0] rgb);
    in_item_t it;
    it.action        = ACT_PALETTE;
    it.palette_index = idx;
    it.palette_red   = rgb[23:16];
    it.palette_green = rgb[15:8];
    it.palette_blue  = rgb[7:0];
    it.data_byte     = $urandom_range(0, 255);
    send_item(it);
    pal_written[idx] = 1'b1;
  endtask

  // Entries that this byte could index are written first, so that no
  // transfer ever reads an undefined palette location.
  task automatic send_byte(logic [7:0] b);
    in_item_t    it;
    int unsigned bpp;
    int unsigned idx;
    bpp = cur_bpp;
    if (cur_bpp == BPP_MONO || cur_bpp == BPP_NIBBLE || cur_bpp == BPP_BYTE) begin
      for (int k = 0; k < 8 / bpp; k++) begin
        idx = (b >> (8 - bpp - k * bpp)) & ((1 << bpp) - 1);
        if (!pal_written[idx]) send_palette(idx, $urandom_range(0, 24'hFF_FFFF));
      end
    end
    it.action        = ACT_DATA;
    it.palette_index = $urandom_range(0, 255);
    it.palette_red   = $urandom_range(0, 255);
    it.palette_green = $urandom_range(0, 255);
    it.palette_blue  = $urandom_range(0, 255);
    it.data_byte     = b;
    send_item(it);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_config(logic [DIM_W-1:0] bpp_word, logic [DIM_W-1:0] w,
                            logic [DIM_W-1:0] h);
    drain();
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_BPP;
    cfg_data_i  <= bpp_word;
    @(posedge clk_i);
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    cfg_index_i <= CFG_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_bpp = bpp_word[BPP_W-1:0];
    settings_used++;
  endtask

  function automatic logic [DIM_W-1:0] pick_dim(int unsigned small_max, int unsigned odds);
    if ($urandom_range(0, odds) != 0) return $urandom_range(1, small_max);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 4096;
      2:       return 8191;
      default: return $urandom_range(13, 8191);
    endcase
  endfunction

  initial begin : pixel_sink
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
    end
  end

  initial begin : stimulus
    logic [BPP_W-1:0] bpp;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    int               n;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_index_i         <= CFG_BPP;
    cfg_data_i          <= '0;
    in_if.valid         <= 1'b0;
    in_if.action        <= ACT_PALETTE;
    in_if.palette_index <= '0;
    in_if.palette_red   <= '0;
    in_if.palette_green <= '0;
    in_if.palette_blue  <= '0;
    in_if.data_byte     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_palette(8'd0, 24'h00_0000);
    send_palette(8'd1, 24'hFF_FFFF);
    send_palette(8'd255, 24'h80_017F);

    // Reset setting is one 24-bit pixel per row: three color bytes, one pad.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h5A);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'hA5);

    // The second byte of each short row ends early at the row width.
    set_config({8'd0, BPP_MONO}, 13'd10, 13'd2);
    send_byte(8'hA5);
    send_byte(8'hC0);
    send_byte(8'h00);
    send_byte(8'hFF);

    set_config({8'd0, BPP_NIBBLE}, 13'd3, 13'd1);
    send_byte(8'h01);
    send_byte(8'h10);
    send_byte(8'h00);
    send_byte(8'h00);

    set_config({8'd0, BPP_BYTE}, 13'd1, 13'd1);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);

    set_config({8'd0, 5'd16}, 13'd2, 13'd2);
    send_byte(8'h3C);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin
          bpp = BPP_MONO;
          w   = 13'd8191;
          h   = 13'd8191;
        end
        1: begin
          bpp = BPP_TRUE;
          w   = 13'd0;
          h   = 13'd0;
        end
        2: begin
          bpp = BPP_NIBBLE;
          w   = 13'd4096;
          h   = 13'd4096;
        end
        3: begin
          bpp = 5'd0;
          w   = 13'd5;
          h   = 13'd2;
        end
        4: begin
          bpp = 5'd31;
          w   = 13'd1;
          h   = 13'd1;
        end
        default: begin
          case ($urandom_range(0, 9))
            0, 1:    bpp = BPP_TRUE;
            2, 3:    bpp = BPP_BYTE;
            4, 5:    bpp = BPP_NIBBLE;
            6, 7:    bpp = BPP_MONO;
            8:       bpp = $urandom_range(0, 31);
            default: bpp = BPP_TRUE;
          endcase
          w = pick_dim(12, 6);
          h = pick_dim(4, 5);
        end
      endcase
      calm = (ph % 4 == 3);
      set_config({8'($urandom_range(0, 255)), bpp}, w, h);
      n = (bpp == BPP_MONO || bpp == BPP_NIBBLE || bpp == BPP_BYTE || bpp == BPP_TRUE)
          ? 24 : 6;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_palette($urandom_range(0, 255), $urandom_range(0, 24'hFF_FFFF));
        end else begin
          send_byte($urandom_range(0, 255));
        end
        if (ph == 6 && i == n / 2) drain();
      end
    end
    calm = 1'b0;

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d items under %0d register settings and compared %0d pixels.",
             items_sent, settings_used, pixel_count);
    $display("Depths 1, 4, 8 and 24 plus unsupported ones; sizes from 0 to 8191.");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
